[src/string_escape_encoder_core_defines.svh]
// Assertion macros for the string escape encoder RTL, used by sesc_back.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef STRING_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define STRING_ESCAPE_ENCODER_CORE_DEFINES_SVH

// Checks a property on every rising edge outside of reset.
`define SESC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sesc assertion failed");

// Same check with a caller supplied message.
`define SESC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

[src/sesc_pkg.sv]
// Package for the string escape encoder: run record type, queue sizing, codes.
// Used by every module of the block; depends on nothing.
package sesc_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SI     = 8'h0F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEXA   = 8'h37;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_run;

    typedef struct packed {
        logic valid;
        t_run run;
    } t_q_head;

    function automatic logic [3:0] digit_remap(input logic [3:0] nib);
        logic [3:0] d;
        case (nib)
            4'd1:    d = 4'd0;
            4'd2:    d = 4'd1;
            4'd3:    d = 4'd2;
            4'd4:    d = 4'd3;
            4'd5:    d = 4'd4;
            4'd6:    d = 4'd5;
            4'd7:    d = 4'd6;
            4'd11:   d = 4'd7;
            4'd12:   d = 4'd8;
            4'd14:   d = 4'd9;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] h;
        if (nib < 4'd10) begin
            h = CH_ZERO + {4'd0, nib};
        end else begin
            h = CH_HEXA + {4'd0, nib};
        end
        return h;
    endfunction

endpackage

[src/string_escape_encoder_core.sv]
// String escape encoder top level: an accepted byte passes through the run queue
// and then the serializer output register, which gives one output byte per cycle
// while i_stall is low; a byte whose escape is n bytes long (1 to 4) gives n bytes.
// A four-entry run queue lets the input keep accepting while the output drains.
// Reset is synchronous and active low; it empties the queue and the output register.
module string_escape_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_src_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic               push;
    logic               full;
    logic               pop;
    sesc_pkg::t_run     run;
    sesc_pkg::t_q_head  head;

    sesc_front u_front (
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_src_byte (i_src_byte),
        .i_full     (full),
        .o_push     (push),
        .o_run      (run)
    );

    sesc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    sesc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

[src/sesc_front.sv]
// Front end: accepts source bytes and classifies each into its escaped run.
// Depends on sesc_pkg; pushes one run record per accepted byte into the queue.
module sesc_front (
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_src_byte,
    input  logic             i_full,
    output logic             o_push,
    output sesc_pkg::t_run   o_run
);

    logic [7:0] c;

    assign c       = i_src_byte;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_run.bytes    = {4{sesc_pkg::CH_BSLASH}};
        o_run.last_idx = 2'd1;
        if (c == sesc_pkg::CH_NUL) begin
            o_run.bytes[0] = sesc_pkg::CH_NUL;
            o_run.last_idx = 2'd0;
        end else if (c == sesc_pkg::CH_DQUOTE || c == sesc_pkg::CH_BSLASH ||
                     c == sesc_pkg::CH_APOS) begin
            o_run.bytes[1] = c;
        end else if (c == sesc_pkg::CH_CR) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_R;
        end else if (c == sesc_pkg::CH_LF) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_N;
        end else if (c == sesc_pkg::CH_TAB) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_T;
        end else if ((c >= 8'd1 && c <= 8'd7) || c == 8'd11 || c == 8'd12 ||
                     c == 8'd14) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_C;
            o_run.bytes[2] = sesc_pkg::CH_ZERO + {4'd0, sesc_pkg::digit_remap(c[3:0])};
            o_run.last_idx = 2'd2;
        end else if (c == sesc_pkg::CH_SI) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_C;
            o_run.bytes[2] = sesc_pkg::CH_LOW_R;
            o_run.last_idx = 2'd2;
        end else if (c < sesc_pkg::CTRL_LIMIT) begin
            o_run.bytes[1] = sesc_pkg::CH_LOW_X;
            o_run.bytes[2] = sesc_pkg::hex_upper(c[7:4]);
            o_run.bytes[3] = sesc_pkg::hex_upper(c[3:0]);
            o_run.last_idx = 2'd3;
        end else begin
            o_run.bytes[0] = c;
            o_run.last_idx = 2'd0;
        end
    end

endmodule

[src/sesc_queue.sv]
// Short queue of run records between the classifier and the serializer.
// Depends on sesc_pkg for the record type and depth.
module sesc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sesc_pkg::t_run      i_run,
    output logic                o_full,
    input  logic                i_pop,
    output sesc_pkg::t_q_head   o_head
);

    sesc_pkg::t_run              r_mem [sesc_pkg::QDEPTH];
    logic [sesc_pkg::QAW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [sesc_pkg::QAW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [sesc_pkg::QAW:0]      r_count, n_count;

    assign o_full       = (r_count == (sesc_pkg::QAW+1)'(sesc_pkg::QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.run   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + {{sesc_pkg::QAW{1'b0}}, i_push} - {{sesc_pkg::QAW{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

endmodule

[src/sesc_back.sv]
// Back end: serializes queued run records into output bytes, one per cycle while i_stall is low.
// Depends on sesc_pkg and the assertion macros in the defines header.
`include "string_escape_encoder_core_defines.svh"

module sesc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sesc_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last
);

    logic       r_valid, n_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic [1:0] r_idx, n_idx;
    logic       load;
    logic       at_last;

    assign load    = i_head.valid && (!r_valid || !i_stall);
    assign at_last = (r_idx == i_head.run.last_idx);
    assign o_pop   = load && at_last;

    always_comb begin
        n_valid = r_valid;
        if (!r_valid || !i_stall) begin
            n_valid = i_head.valid;
        end
        n_idx = r_idx;
        if (load) begin
            n_idx = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.run.bytes[r_idx];
            r_run_last <= at_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_run_last;

    `SESC_ASSERT(a_idx_needs_head, r_idx != 2'd0 |-> i_head.valid)
    `SESC_ASSERT(a_idx_in_run, i_head.valid |-> r_idx <= i_head.run.last_idx)
    `SESC_ASSERT_MSG(a_pop_marks_last, o_pop |=> (r_valid && r_run_last), "pop without last mark")

endmodule
